### hdl/agp_pkg.sv
// ============================================================================
// agp_pkg: shared types and constants of the affine grid point generator
// Field widths, payload structs of the channels and the register index codes.
// ============================================================================
`default_nettype none

package agp_pkg;

   // Fixed field widths
   localparam int IDX_W     = 12;   // grid index
   localparam int SIZE_W    = 13;   // configured axis size
   localparam int COEF_W    = 16;   // signed Q4.12 matrix coefficient
   localparam int COEF_FRAC = 12;
   localparam int OUT_W     = 24;   // transformed coordinate
   localparam int CSR_W     = 64;

   // Largest axis size; bigger sizes are clamped to it
   localparam int MAX_DIM = 4096;

   // Saturation limits of a transformed coordinate
   localparam int OUT_MAX = 8388607;
   localparam int OUT_MIN = -8388608;

   // Register indexes of the configuration port
   typedef enum logic [2:0] {
      CSR_MODE_3D       = 3'd0,
      CSR_ALIGN_CORNERS = 3'd1,
      CSR_GRID_WIDTH    = 3'd2,
      CSR_GRID_HEIGHT   = 3'd3,
      CSR_GRID_DEPTH    = 3'd4,
      CSR_MATRIX_ROW_X  = 3'd5,
      CSR_MATRIX_ROW_Y  = 3'd6,
      CSR_MATRIX_ROW_Z  = 3'd7
   } csr_index_type;

   // Request payload: one grid point
   typedef struct packed {
      logic [IDX_W-1:0] column_index;
      logic [IDX_W-1:0] row_index;
      logic [IDX_W-1:0] slice_index;
   } req_type;

   // Response payload: transformed point
   typedef struct packed {
      logic signed [OUT_W-1:0] point_x;
      logic signed [OUT_W-1:0] point_y;
      logic signed [OUT_W-1:0] point_z;
      logic                    index_error;
   } rsp_type;

   // Configuration write payload
   typedef struct packed {
      csr_index_type    index;
      logic [CSR_W-1:0] data;
   } csr_type;

   // Axis size clamped to MAX_DIM
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size);
      return (32'(size) > 32'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : size;
   endfunction

endpackage

`default_nettype wire

### hdl/agp_stream_if.sv
// ============================================================================
// agp_stream_if: valid/ready channel
// Carries one payload per transfer; a transfer happens when valid and ready
// are both high at a rising clock edge.
// ============================================================================
`default_nettype none

interface agp_stream_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

### hdl/affine_grid_point_generator.sv
// Pipeline: input register, divider setup, divider stages, then coordinate, product,
//   sum and output stages between request transfer and response valid.
// Throughput: one point per cycle; a stalled response holds its stage while
//   bubbles further back still close up.
// Reset: synchronous, clears all stage valid bits and loads the register
//   defaults (2D, edges at +-1, all sizes 1, zero matrix).
// ============================================================================
// affine_grid_point_generator: grid index to transformed coordinate
// Normalizes each index to [-1, 1] in fixed point through a restoring divider
// pipeline, then applies the 3x4 (or 2x3) affine matrix and saturates.
// ============================================================================
`default_nettype none

module affine_grid_point_generator
   import agp_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   agp_stream_if.sink    req_chan,
   agp_stream_if.source  rsp_chan,
   agp_stream_if.sink    csr_chan
);

   // Derived widths
   localparam int QB         = FRAC_BITS + 1;              // quotient bits
   localparam int DW         = SIZE_W + 1;                 // divisor / remainder
   localparam int AW         = SIZE_W + QB + 1;            // dividend
   localparam int STEPS      = 4;                          // divide steps per stage
   localparam int DIV_STAGES = (QB + STEPS - 1) / STEPS;
   localparam int CW         = FRAC_BITS + 2;              // normalized coordinate
   localparam int PW         = COEF_W + CW;                // product
   localparam int SW         = PW + 2;                     // accumulator
   localparam int TW         = SW - COEF_FRAC;             // after rounding shift
   localparam int QW         = (TW > OUT_W) ? TW : OUT_W + 1;

   // Stage positions
   localparam int CS = 2 + DIV_STAGES;   // coordinate
   localparam int MS = CS + 1;           // products
   localparam int AS = MS + 1;           // sums
   localparam int OS = AS + 1;           // output register
   localparam int NS = OS + 1;

   localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) <<< (COEF_FRAC - 1);
   localparam logic signed [QW-1:0] SAT_HI     = QW'(OUT_MAX);
   localparam logic signed [QW-1:0] SAT_LO     = QW'(OUT_MIN);

   typedef struct packed {
      logic       err;
      logic       three;
      logic [2:0] neg;
      logic [2:0] unit;
   } side_type;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic              mode_3d_ff;
   logic              align_ff;
   logic [SIZE_W-1:0] width_ff;
   logic [SIZE_W-1:0] height_ff;
   logic [SIZE_W-1:0] depth_ff;
   logic [CSR_W-1:0]  row_ff [3];

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_3d_ff <= 1'b0;
         align_ff   <= 1'b0;
         width_ff   <= SIZE_W'(1);
         height_ff  <= SIZE_W'(1);
         depth_ff   <= SIZE_W'(1);
         row_ff[0]  <= '0;
         row_ff[1]  <= '0;
         row_ff[2]  <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.payload.index)
            CSR_MODE_3D:       mode_3d_ff <= csr_chan.payload.data[0];
            CSR_ALIGN_CORNERS: align_ff   <= csr_chan.payload.data[0];
            CSR_GRID_WIDTH:    width_ff   <= csr_chan.payload.data[SIZE_W-1:0];
            CSR_GRID_HEIGHT:   height_ff  <= csr_chan.payload.data[SIZE_W-1:0];
            CSR_GRID_DEPTH:    depth_ff   <= csr_chan.payload.data[SIZE_W-1:0];
            CSR_MATRIX_ROW_X:  row_ff[0]  <= csr_chan.payload.data;
            CSR_MATRIX_ROW_Y:  row_ff[1]  <= csr_chan.payload.data;
            CSR_MATRIX_ROW_Z:  row_ff[2]  <= csr_chan.payload.data;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Stage valid bits and per-stage advance
   // ------------------------------------------------------------------------
   logic [NS-1:0] v_ff;
   logic [NS:0]   en;

   // A stage loads when it is empty or its content moves on
   always_comb begin
      en[NS] = rsp_chan.ready;
      for (int k = NS - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_chan.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_chan.valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage 0: input register
   // ------------------------------------------------------------------------
   req_type in_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         in_ff <= req_chan.payload;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: range check, numerator sign/magnitude, divider setup
   // q = floor((mag * 2^(F+1) + den) / (2 * den))
   // ------------------------------------------------------------------------
   logic [IDX_W-1:0]  idx      [3];
   logic [SIZE_W-1:0] size_eff [3];
   logic [DW-1:0]     prep_r_in [3];
   logic [QB-1:0]     prep_q_in [3];
   logic [DW-1:0]     prep_d_in [3];
   side_type          prep_side_in;

   assign idx[0]      = in_ff.column_index;
   assign idx[1]      = in_ff.row_index;
   assign idx[2]      = in_ff.slice_index;
   assign size_eff[0] = eff_size(width_ff);
   assign size_eff[1] = eff_size(height_ff);
   assign size_eff[2] = eff_size(depth_ff);

   always_comb begin
      logic [SIZE_W-1:0] den;
      logic [SIZE_W:0]   diff;
      logic [SIZE_W-1:0] mag;
      logic [AW-1:0]     dvd;
      logic [2:0]        lane_err;
      prep_side_in = '0;
      for (int l = 0; l < 3; l++) begin
         // aligned: 2i-(n-1) over n-1; otherwise 2i+1-n over n
         den  = size_eff[l] - SIZE_W'(align_ff);
         diff = {1'b0, idx[l], ~align_ff} - {1'b0, den};
         mag  = diff[SIZE_W] ? SIZE_W'(-diff) : diff[SIZE_W-1:0];
         dvd  = AW'({mag, {QB{1'b0}}}) + AW'(den);
         prep_r_in[l] = dvd[AW-1:QB];
         prep_q_in[l] = dvd[QB-1:0];
         prep_d_in[l] = {den, 1'b0};
         prep_side_in.neg[l]  = diff[SIZE_W];
         prep_side_in.unit[l] = align_ff && (size_eff[l] == SIZE_W'(1));
         lane_err[l] = SIZE_W'(idx[l]) >= size_eff[l];
      end
      prep_side_in.three = mode_3d_ff;
      prep_side_in.err   = lane_err[0] || lane_err[1] || (mode_3d_ff && lane_err[2]);
   end

   // Divider pipeline state; entry s feeds divider stage s
   logic [DW-1:0] div_r_ff [DIV_STAGES+1][3];
   logic [QB-1:0] div_q_ff [DIV_STAGES+1][3];
   logic [DW-1:0] div_d_ff [DIV_STAGES+1][3];
   side_type      side_ff  [1:AS];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         div_r_ff[0] <= prep_r_in;
         div_q_ff[0] <= prep_q_in;
         div_d_ff[0] <= prep_d_in;
         side_ff[1]  <= prep_side_in;
      end
   end

   // ------------------------------------------------------------------------
   // Restoring divider, up to STEPS quotient bits per stage, three lanes
   // ------------------------------------------------------------------------
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      logic [DW-1:0] r_in [3];
      logic [QB-1:0] q_in [3];

      always_comb begin
         logic [DW:0] rem;
         rem = '0;
         for (int l = 0; l < 3; l++) begin
            r_in[l] = div_r_ff[s][l];
            q_in[l] = div_q_ff[s][l];
            for (int j = 0; j < STEPS; j++) begin
               if (s * STEPS + j < QB) begin
                  rem = {r_in[l], q_in[l][QB-1]};
                  if (rem >= {1'b0, div_d_ff[s][l]}) begin
                     rem     = rem - {1'b0, div_d_ff[s][l]};
                     q_in[l] = {q_in[l][QB-2:0], 1'b1};
                  end else begin
                     q_in[l] = {q_in[l][QB-2:0], 1'b0};
                  end
                  r_in[l] = rem[DW-1:0];
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[2+s]) begin
            div_r_ff[s+1]  <= r_in;
            div_q_ff[s+1]  <= q_in;
            div_d_ff[s+1]  <= div_d_ff[s];
            side_ff[2+s]   <= side_ff[1+s];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Coordinate stage: apply sign, single-pixel aligned axis gives -1
   // ------------------------------------------------------------------------
   logic signed [CW-1:0] coord_in [3];
   logic signed [CW-1:0] coord_ff [3];

   always_comb begin
      logic signed [CW-1:0] qs;
      for (int l = 0; l < 3; l++) begin
         qs = $signed({1'b0, div_q_ff[DIV_STAGES][l]});
         if (side_ff[CS-1].unit[l]) begin
            coord_in[l] = $signed({2'b11, {FRAC_BITS{1'b0}}});
         end else if (side_ff[CS-1].neg[l]) begin
            coord_in[l] = -qs;
         end else begin
            coord_in[l] = qs;
         end
      end
      // depth axis drops out of a 2D grid
      if (!side_ff[CS-1].three) begin
         coord_in[2] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[CS]) begin
         coord_ff      <= coord_in;
         side_ff[CS]   <= side_ff[CS-1];
      end
   end

   // ------------------------------------------------------------------------
   // Product stage: nine coefficient by coordinate products
   // ------------------------------------------------------------------------
   logic signed [PW-1:0] prod_in [3][3];
   logic signed [PW-1:0] prod_ff [3][3];

   always_comb begin
      logic signed [COEF_W-1:0] coef;
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            coef          = $signed(row_ff[r][COEF_W*k +: COEF_W]);
            prod_in[r][k] = coef * coord_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[MS]) begin
         prod_ff     <= prod_in;
         side_ff[MS] <= side_ff[MS-1];
      end
   end

   // ------------------------------------------------------------------------
   // Sum stage: products, constant term and rounding half
   // ------------------------------------------------------------------------
   logic signed [SW-1:0] sum_in [3];
   logic signed [SW-1:0] sum_ff [3];

   always_comb begin
      logic signed [COEF_W-1:0] cterm;
      for (int r = 0; r < 3; r++) begin
         cterm     = $signed(row_ff[r][COEF_W*3 +: COEF_W]);
         sum_in[r] = SW'(prod_ff[r][0]) + SW'(prod_ff[r][1]) + SW'(prod_ff[r][2])
                   + (SW'(cterm) <<< FRAC_BITS) + ROUND_HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (en[AS]) begin
         sum_ff      <= sum_in;
         side_ff[AS] <= side_ff[AS-1];
      end
   end

   // ------------------------------------------------------------------------
   // Output stage: floor shift, saturate, zero on error
   // ------------------------------------------------------------------------
   function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [SW-1:0] acc);
      logic signed [QW-1:0] q;
      q = QW'($signed(acc[SW-1:COEF_FRAC]));
      if (q > SAT_HI) begin
         return OUT_W'(SAT_HI);
      end else if (q < SAT_LO) begin
         return OUT_W'(SAT_LO);
      end
      return q[OUT_W-1:0];
   endfunction

   rsp_type rsp_in;
   rsp_type rsp_ff;

   always_comb begin
      rsp_in.index_error = side_ff[OS-1].err;
      rsp_in.point_x     = '0;
      rsp_in.point_y     = '0;
      rsp_in.point_z     = '0;
      if (!side_ff[OS-1].err) begin
         rsp_in.point_x = round_sat(sum_ff[0]);
         rsp_in.point_y = round_sat(sum_ff[1]);
         if (side_ff[OS-1].three) begin
            rsp_in.point_z = round_sat(sum_ff[2]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[OS]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid   = v_ff[OS];
   assign rsp_chan.payload = rsp_ff;

endmodule

`default_nettype wire

### hdl/agp_checker.sv
// ============================================================================
// agp_checker: port-level checks of the affine grid point generator
// Watches the channels only and keeps a shadow of the 3D mode bit.
// ============================================================================
`default_nettype none

module agp_checker
   import agp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload,
   input logic    csr_valid,
   input logic    csr_ready,
   input csr_type csr_payload
);

   // Shadow of the mode register from configuration transfers
   logic mode_shadow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_shadow_ff <= 1'b0;
      end else if (csr_valid && csr_ready && csr_payload.index == CSR_MODE_3D) begin
         mode_shadow_ff <= csr_payload.data[0];
      end
   end

   // Nothing comes out right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // An out-of-range point reports zero coordinates
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.index_error |->
         rsp_payload.point_x == '0 && rsp_payload.point_y == '0 &&
         rsp_payload.point_z == '0)
      else $error("index error with nonzero coordinates");

   // A 2D grid leaves z at zero
   a_2d_z_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !mode_shadow_ff |-> rsp_payload.point_z == '0)
      else $error("nonzero z in 2D mode");

endmodule

bind affine_grid_point_generator agp_checker u_agp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload),
   .csr_valid   (csr_chan.valid),
   .csr_ready   (csr_chan.ready),
   .csr_payload (csr_chan.payload)
);

`default_nettype wire

### verif/tb_affine_grid_point_generator.sv
// ============================================================================
// tb_affine_grid_point_generator: self-checking testbench of the generator
// Drives grid points through the request channel with random gaps and
// back-pressures the response channel at random. A directed table covers
// reset defaults, the index and size extremes, both modes and both corner
// alignments. Random phases follow, each with a fresh register setting.
// Every response is checked field by field against a point predictor kept
// in this bench, or against the known result of its directed table row.
// ============================================================================
`default_nettype none

module tb_affine_grid_point_generator;
   timeunit 1ns;
   timeprecision 1ps;

   import agp_pkg::*;

   localparam int FRAC          = 16;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 155;
   localparam int MAX_IDLE      = 17;
   localparam int TAIL_CYCLES   = 24;
   localparam int MAX_REPORTS   = 10;

   typedef enum bit {STEP_WRITE, STEP_POINT} step_kind_type;

   // One row of the directed table: a register write or a grid point
   typedef struct {
      step_kind_type kind;
      csr_index_type index;
      logic [63:0]   data;
      req_type       point;
      bit            has_known;
      rsp_type       known;
   } step_type;

   logic clock = 1'b0;
   logic reset;

   agp_stream_if #(.payload_type(req_type)) req_if ();
   agp_stream_if #(.payload_type(rsp_type)) rsp_if ();
   agp_stream_if #(.payload_type(csr_type)) csr_if ();

   affine_grid_point_generator DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // Register copy used for prediction
   bit          cfg_mode_3d;
   bit          cfg_align;
   logic [12:0] cfg_width;
   logic [12:0] cfg_height;
   logic [12:0] cfg_depth;
   logic [63:0] cfg_row_x;
   logic [63:0] cfg_row_y;
   logic [63:0] cfg_row_z;

   rsp_type  pending_points[$];
   step_type directed_steps[$];
   int       mismatch_count = 0;
   int       cycle_count    = 0;
   bit       no_idle        = 1'b0;

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic void load_defaults();
      cfg_mode_3d = 1'b0;
      cfg_align   = 1'b0;
      cfg_width   = 13'd1;
      cfg_height  = 13'd1;
      cfg_depth   = 13'd1;
      cfg_row_x   = '0;
      cfg_row_y   = '0;
      cfg_row_z   = '0;
   endfunction

   function automatic void apply_write(csr_index_type idx, logic [63:0] data);
      case (idx)
         CSR_MODE_3D:       cfg_mode_3d = data[0];
         CSR_ALIGN_CORNERS: cfg_align   = data[0];
         CSR_GRID_WIDTH:    cfg_width   = data[12:0];
         CSR_GRID_HEIGHT:   cfg_height  = data[12:0];
         CSR_GRID_DEPTH:    cfg_depth   = data[12:0];
         CSR_MATRIX_ROW_X:  cfg_row_x   = data;
         CSR_MATRIX_ROW_Y:  cfg_row_y   = data;
         CSR_MATRIX_ROW_Z:  cfg_row_z   = data;
         default: ;
      endcase
   endfunction

   // Axis size after clamping to MAX_DIM
   function automatic longint axis_size(logic [12:0] size);
      return (longint'(size) > MAX_DIM) ? longint'(MAX_DIM) : longint'(size);
   endfunction

   // Index to [-1, 1] in Q.16, rounded to nearest, ties away from zero
   function automatic longint normalize(longint i, longint n, bit aligned);
      longint num, den, mag, q;
      if (aligned) begin
         if (n == 1) return -(longint'(1) << FRAC);
         num = 2 * i - (n - 1);
         den = n - 1;
      end else begin
         num = 2 * i + 1 - n;
         den = n;
      end
      if (den <= 0) return 0;
      mag = (num < 0 ? -num : num) << FRAC;
      q   = (2 * mag + den) / (2 * den);
      return (num < 0) ? -q : q;
   endfunction

   // One matrix row applied to the point, rounded by floor(v + 1/2), saturated
   function automatic logic [OUT_W-1:0] transform_row(logic [63:0] row, longint x,
                                                      longint y, longint z, bit three);
      longint acc;
      acc = longint'($signed(row[15:0])) * x + longint'($signed(row[31:16])) * y
          + longint'($signed(row[63:48])) * (longint'(1) << FRAC);
      if (three) acc += longint'($signed(row[47:32])) * z;
      acc = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
      if (acc > OUT_MAX) acc = OUT_MAX;
      if (acc < OUT_MIN) acc = OUT_MIN;
      return acc[OUT_W-1:0];
   endfunction

   function automatic rsp_type predict_point(req_type p);
      longint  nw, nh, nd, x, y, z;
      rsp_type r;
      nw = axis_size(cfg_width);
      nh = axis_size(cfg_height);
      nd = axis_size(cfg_depth);
      r  = '0;
      if (longint'(p.column_index) >= nw || longint'(p.row_index) >= nh ||
          (cfg_mode_3d && longint'(p.slice_index) >= nd)) begin
         r.index_error = 1'b1;
         return r;
      end
      x = normalize(longint'(p.column_index), nw, cfg_align);
      y = normalize(longint'(p.row_index), nh, cfg_align);
      z = cfg_mode_3d ? normalize(longint'(p.slice_index), nd, cfg_align) : 0;
      r.point_x = transform_row(cfg_row_x, x, y, z, cfg_mode_3d);
      r.point_y = transform_row(cfg_row_y, x, y, z, cfg_mode_3d);
      r.point_z = cfg_mode_3d ? transform_row(cfg_row_z, x, y, z, 1'b1) : '0;
      return r;
   endfunction

   // Directed table rows
   function automatic void write_step(csr_index_type idx, logic [63:0] data);
      step_type s;
      s.kind      = STEP_WRITE;
      s.index     = idx;
      s.data      = data;
      s.point     = '0;
      s.has_known = 1'b0;
      s.known     = '0;
      directed_steps = {directed_steps, s};
   endfunction

   function automatic void point_step(int c, int r, int d);
      step_type s;
      s.kind      = STEP_POINT;
      s.index     = CSR_MODE_3D;
      s.data      = '0;
      s.point     = '{column_index: 12'(c), row_index: 12'(r), slice_index: 12'(d)};
      s.has_known = 1'b0;
      s.known     = '0;
      directed_steps = {directed_steps, s};
   endfunction

   // Point whose result is all zero coordinates, with or without the error flag
   function automatic void known_step(int c, int r, int d, bit err);
      point_step(c, r, d);
      directed_steps[$].has_known         = 1'b1;
      directed_steps[$].known.index_error = err;
   endfunction

   // Random register contents; upper bits carry noise to test masking
   function automatic logic [63:0] size_word();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      case ($urandom_range(0, 19))
         0:       w[12:0] = 13'd0;
         1, 2:    w[12:0] = 13'd4096;
         3, 4:    w[12:0] = 13'($urandom_range(4097, 8191));
         5:       w[12:0] = 13'd1;
         6, 7, 8: w[12:0] = 13'($urandom_range(2, 4095));
         default: w[12:0] = 13'($urandom_range(1, 16));
      endcase
      return w;
   endfunction

   function automatic logic [63:0] matrix_word();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      if ($urandom_range(0, 2) == 0) begin
         for (int k = 0; k < 4; k++)
            w[16*k +: 16] = 16'($urandom_range(0, 16383)) - 16'd8192;
      end
      return w;
   endfunction

   // Mostly in-range indices, some out-of-range noise
   function automatic logic [IDX_W-1:0] pick_index(logic [12:0] size);
      longint n;
      n = axis_size(size);
      if (n == 0 || $urandom_range(0, 9) == 0) return IDX_W'($urandom_range(0, 4095));
      return IDX_W'($urandom_range(0, int'(n - 1)));
   endfunction

   // Called at a falling edge; leaves at a falling edge
   task automatic send_point(req_type p, bit has_known, rsp_type known);
      int      gap;
      rsp_type want;
      gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.payload <= p;
      req_if.valid   <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      want = has_known ? known : predict_point(p);
      pending_points = {pending_points, want};
      @(negedge clock);
   endtask

   // Stop sending and wait for every outstanding result
   task automatic drain_points();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (pending_points.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [63:0] data);
      csr_if.payload <= '{index: idx, data: data};
      csr_if.valid   <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      apply_write(idx, data);
      @(negedge clock);
      csr_if.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_point(rsp_type got);
      rsp_type want;
      if (pending_points.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: x=%0d y=%0d z=%0d err=%0b", got.point_x,
                     got.point_y, got.point_z, got.index_error);
         return;
      end
      want = pending_points.pop_front();
      if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
          got.point_z !== want.point_z || got.index_error !== want.index_error) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: expected x=%0d y=%0d z=%0d err=%0b, got x=%0d y=%0d z=%0d err=%0b",
                     want.point_x, want.point_y, want.point_z, want.index_error,
                     got.point_x, got.point_y, got.point_z, got.index_error);
      end
   endtask

   // Response side: random stall before each transfer
   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         check_point(rsp_if.payload);
         @(negedge clock);
      end
   end

   // Stimulus
   initial begin
      req_type p;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      csr_if.valid   = 1'b0;
      csr_if.payload = '0;
      load_defaults();

      // Reset defaults: 2D, all sizes 1, zero matrix
      known_step(0, 0, 0, 1'b0);
      known_step(1, 0, 0, 1'b1);
      known_step(0, 1, 0, 1'b1);
      known_step(0, 0, 4095, 1'b0);        // slice ignored in 2D
      known_step(4095, 4095, 4095, 1'b1);
      // 3D, aligned corners, oversize height, zero depth
      write_step(CSR_MODE_3D, 64'd1);
      write_step(CSR_ALIGN_CORNERS, 64'd1);
      write_step(CSR_GRID_WIDTH, 64'd4096);
      write_step(CSR_GRID_HEIGHT, 64'd8191);
      write_step(CSR_GRID_DEPTH, 64'd0);
      write_step(CSR_MATRIX_ROW_X, 64'h0000_0000_0000_1000);
      write_step(CSR_MATRIX_ROW_Y, 64'h0000_0000_1000_0000);
      write_step(CSR_MATRIX_ROW_Z, 64'h0000_1000_0000_0000);
      known_step(0, 0, 0, 1'b1);           // zero depth: always out of range
      write_step(CSR_GRID_DEPTH, 64'd1);
      point_step(0, 0, 0);                 // single slice with aligned corners
      point_step(4095, 4095, 0);
      point_step(2048, 2047, 0);
      known_step(4095, 0, 1, 1'b1);
      // Extreme coefficients
      write_step(CSR_GRID_DEPTH, 64'd4097);
      write_step(CSR_MATRIX_ROW_X, 64'h7FFF_7FFF_7FFF_7FFF);
      write_step(CSR_MATRIX_ROW_Y, 64'h8000_8000_8000_8000);
      write_step(CSR_MATRIX_ROW_Z, 64'h8000_7FFF_0001_FFFF);
      point_step(4095, 4095, 4095);
      point_step(0, 0, 0);
      point_step(0, 4095, 2048);
      point_step(1365, 2730, 4095);
      // 2D, edges at +-1, an odd width for rounding
      write_step(CSR_ALIGN_CORNERS, 64'd0);
      write_step(CSR_MODE_3D, 64'd0);
      write_step(CSR_GRID_WIDTH, 64'd3);
      write_step(CSR_GRID_HEIGHT, 64'd2);
      write_step(CSR_MATRIX_ROW_X, 64'h0800_1000_7FFF_0001);
      point_step(0, 0, 4095);
      point_step(1, 1, 0);
      point_step(2, 0, 0);
      known_step(3, 0, 0, 1'b1);
      known_step(0, 2, 0, 1'b1);
      // Single column with aligned corners
      write_step(CSR_GRID_WIDTH, 64'd1);
      write_step(CSR_ALIGN_CORNERS, 64'd1);
      point_step(0, 1, 0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_WRITE) begin
            drain_points();
            write_reg(directed_steps[i].index, directed_steps[i].data);
         end else begin
            send_point(directed_steps[i].point, directed_steps[i].has_known,
                       directed_steps[i].known);
         end
      end

      // Random phases, each with its own register setting
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_points();
         no_idle = 1'b0;
         write_reg(CSR_MODE_3D, {$urandom(), $urandom()});
         write_reg(CSR_ALIGN_CORNERS, {$urandom(), $urandom()});
         write_reg(CSR_GRID_WIDTH, size_word());
         write_reg(CSR_GRID_HEIGHT, size_word());
         write_reg(CSR_GRID_DEPTH, size_word());
         write_reg(CSR_MATRIX_ROW_X, matrix_word());
         write_reg(CSR_MATRIX_ROW_Y, matrix_word());
         write_reg(CSR_MATRIX_ROW_Z, matrix_word());
         no_idle = (phase % 4 == 1);
         for (int item = 0; item < PHASE_ITEMS; item++) begin
            // sender holds off until the pipeline is empty
            if (phase % 3 == 0 && item == PHASE_ITEMS / 2) drain_points();
            p.column_index = pick_index(cfg_width);
            p.row_index    = pick_index(cfg_height);
            p.slice_index  = pick_index(cfg_depth);
            send_point(p, 1'b0, '0);
         end
      end

      drain_points();
      no_idle = 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_points.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire
